@@ hw/rtl/fpa_pkg.sv @@
// ---------------------------------------------------------------------------
// fpa_pkg
// Shared constants, command and status codes and types of the Q24.8 ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_W    = 32;
	localparam int INT_W     = 24;
	localparam int CMD_W     = 5;

	// divider: two quotient bits per stage over the padded dividend
	localparam int DIV_STAGES = (WORD_W + FRAC_BITS + 1) / 2;
	localparam int DVD_W      = 2 * DIV_STAGES;
	localparam int SIDE_LAT   = 3;
	localparam int SIDE_DLY   = DIV_STAGES - SIDE_LAT;
	localparam int PIPE_DEPTH = DIV_STAGES + 2;

	localparam logic [CMD_W-1:0] CMD_ADD        = 5'd0;
	localparam logic [CMD_W-1:0] CMD_SUB        = 5'd1;
	localparam logic [CMD_W-1:0] CMD_MUL        = 5'd2;
	localparam logic [CMD_W-1:0] CMD_DIV        = 5'd3;
	localparam logic [CMD_W-1:0] CMD_LT         = 5'd4;
	localparam logic [CMD_W-1:0] CMD_LE         = 5'd5;
	localparam logic [CMD_W-1:0] CMD_GT         = 5'd6;
	localparam logic [CMD_W-1:0] CMD_GE         = 5'd7;
	localparam logic [CMD_W-1:0] CMD_EQ         = 5'd8;
	localparam logic [CMD_W-1:0] CMD_MIN        = 5'd9;
	localparam logic [CMD_W-1:0] CMD_MAX        = 5'd10;
	localparam logic [CMD_W-1:0] CMD_FROM_INT   = 5'd11;
	localparam logic [CMD_W-1:0] CMD_TO_INT     = 5'd12;
	localparam logic [CMD_W-1:0] CMD_FROM_FLOAT = 5'd13;
	localparam logic [CMD_W-1:0] CMD_TO_FLOAT   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_INC        = 5'd15;
	localparam logic [CMD_W-1:0] CMD_DEC        = 5'd16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_DIV0  = 2'd2;
	localparam logic [1:0] ST_INVAL = 2'd3;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_raw;
		logic                     compare_true;
		logic signed [INT_W-1:0]  int_result;
		logic [WORD_W-1:0]        float_result_bits;
		logic [1:0]               status;
	} res_t;

	typedef struct packed {
		logic is_div;
		logic neg;
		logic zero;
	} div_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpa_if.sv @@
// ---------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels carrying ALU operations and ALU results.
// ---------------------------------------------------------------------------
`default_nettype none

interface fpa_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         cmd;
	logic signed [31:0] a_raw;
	logic signed [31:0] b_raw;
	logic [31:0]        scalar_in;

	modport source(output valid, cmd, a_raw, b_raw, scalar_in, input ready);
	modport sink(input valid, cmd, a_raw, b_raw, scalar_in, output ready);
endinterface

interface fpa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_raw;
	logic               compare_true;
	logic signed [23:0] int_result;
	logic [31:0]        float_result_bits;
	logic [1:0]         status;

	modport source(output valid, result_raw, compare_true, int_result,
		float_result_bits, status, input ready);
	modport sink(input valid, result_raw, compare_true, int_result,
		float_result_bits, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fpa_div.sv @@
// ---------------------------------------------------------------------------
// fpa_div
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_div (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [fpa_pkg::DVD_W-1:0]  dividend,
	input  wire logic [fpa_pkg::WORD_W-1:0] divisor,
	output logic [fpa_pkg::DVD_W-1:0]       quotient
);

	localparam int NS = fpa_pkg::DIV_STAGES;
	localparam int DW = fpa_pkg::DVD_W;
	localparam int WW = fpa_pkg::WORD_W;

	// n holds remaining dividend bits on top, quotient bits shift in below
	logic [WW-1:0] rem_s [NS];
	logic [DW-1:0] n_s   [NS];
	logic [WW-1:0] d_s   [NS];

	logic [WW-1:0] rem_nx [NS];
	logic [DW-1:0] n_nx   [NS];
	logic [WW-1:0] d_nx   [NS];

	always_comb begin
		logic [WW-1:0] r;
		logic [DW-1:0] n;
		logic [WW-1:0] d;
		logic [WW:0]   t;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				r = '0;
				n = dividend;
				d = divisor;
			end else begin
				r = rem_s[i-1];
				n = n_s[i-1];
				d = d_s[i-1];
			end
			for (int k = 0; k < 2; k++) begin
				t = {r, n[DW-1]};
				if (t >= {1'b0, d}) begin
					t = t - {1'b0, d};
					n = {n[DW-2:0], 1'b1};
				end else begin
					n = {n[DW-2:0], 1'b0};
				end
				r = t[WW-1:0];
			end
			rem_nx[i] = r;
			n_nx[i]   = n;
			d_nx[i]   = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NS; i++) begin
				rem_s[i] <= rem_nx[i];
				n_s[i]   <= n_nx[i];
				d_s[i]   <= d_nx[i];
			end
		end
	end

	assign quotient = n_s[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/fpa_arith.sv @@
// ---------------------------------------------------------------------------
// fpa_arith
// Add/sub/inc/dec, compares, min/max, integer conversions and multiply.
// Three register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_arith (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [4:0]         cmd,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	input  wire logic [31:0]        scalar,
	output fpa_pkg::res_t           res
);

	localparam int FB = fpa_pkg::FRAC_BITS;
	localparam int IW = fpa_pkg::INT_W;

	fpa_pkg::res_t      fast, mul_res;
	fpa_pkg::res_t      fast_s2, res_s3, res_s4;
	logic signed [63:0] prod_s2;
	logic               mul_s2;

	always_comb begin
		logic signed [32:0] ax, yx, sum;
		logic signed [31:0] fl;
		logic               sub;
		ax  = {a[31], a};
		sub = (cmd == fpa_pkg::CMD_SUB) || (cmd == fpa_pkg::CMD_DEC);
		if ((cmd == fpa_pkg::CMD_INC) || (cmd == fpa_pkg::CMD_DEC))
			yx = 33'sd1;
		else
			yx = {b[31], b};
		sum  = sub ? (ax - yx) : (ax + yx);
		fl   = a >>> FB;
		fast = '0;
		case (cmd)
			fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
				fast.result_raw = sum[31:0];
				fast.status     = (sum[32] != sum[31]) ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
			end
			fpa_pkg::CMD_LT: fast.compare_true = (a < b);
			fpa_pkg::CMD_LE: fast.compare_true = (a <= b);
			fpa_pkg::CMD_GT: fast.compare_true = (a > b);
			fpa_pkg::CMD_GE: fast.compare_true = (a >= b);
			fpa_pkg::CMD_EQ: fast.compare_true = (a == b);
			fpa_pkg::CMD_MIN: fast.result_raw = (a < b) ? a : b;
			fpa_pkg::CMD_MAX: fast.result_raw = (a > b) ? a : b;
			fpa_pkg::CMD_FROM_INT: begin
				fast.result_raw = scalar << FB;
				if ((scalar[31:31-FB] != '0) && (scalar[31:31-FB] != '1))
					fast.status = fpa_pkg::ST_OVF;
			end
			fpa_pkg::CMD_TO_INT: begin
				fast.int_result = fl[IW-1:0];
				if ((fl[31:IW-1] != '0) && (fl[31:IW-1] != '1))
					fast.status = fpa_pkg::ST_OVF;
			end
			default: fast = '0;
		endcase
	end

	// multiply result: arithmetic shift gives floor
	always_comb begin
		logic signed [63:0] pr;
		pr                 = prod_s2 >>> FB;
		mul_res            = '0;
		mul_res.result_raw = pr[31:0];
		if ((pr[63:31] != '0) && (pr[63:31] != '1))
			mul_res.status = fpa_pkg::ST_OVF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fast_s2 <= fast;
			prod_s2 <= a * b;
			mul_s2  <= (cmd == fpa_pkg::CMD_MUL);
			res_s3  <= mul_s2 ? mul_res : fast_s2;
			res_s4  <= res_s3;
		end
	end

	assign res = res_s4;

endmodule

`default_nettype wire

@@ hw/rtl/fpa_cvt.sv @@
// ---------------------------------------------------------------------------
// fpa_cvt
// IEEE single to fixed and fixed to IEEE single. Three register stages:
// decode, shift/encode, round/saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_cvt (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [4:0]         cmd,
	input  wire logic signed [31:0] a,
	input  wire logic [31:0]        scalar,
	output fpa_pkg::res_t           res
);

	localparam int FB = fpa_pkg::FRAC_BITS;
	localparam logic signed [9:0] SH_OFS = 10'(FB - 150);
	localparam logic [7:0] EXP_OFS = 8'(127 - FB);

	// stage 2
	logic [4:0]         cmd_s2;
	logic               fneg_s2, fnan_s2, finf_s2;
	logic [23:0]        fmag_s2;
	logic signed [9:0]  fsh_s2;
	logic               xneg_s2;
	logic [31:0]        xmag_s2;
	// stage 3
	logic [4:0]         cmd_s3;
	logic               fneg_s3, fnan_s3, fsat_s3;
	logic [54:0]        fq_s3;
	logic               xneg_s3, xzero_s3;
	logic [31:0]        xmag_s3;
	logic [4:0]         xp_s3;
	// stage 4
	fpa_pkg::res_t      res_s4;

	logic [7:0]        e_eff;
	logic signed [9:0] sh_s1;
	logic [54:0]       fq;
	logic              fsat;
	logic [4:0]        xp;
	fpa_pkg::res_t     res_nx;

	assign e_eff = (scalar[30:23] == 8'd0) ? 8'd1 : scalar[30:23];
	assign sh_s1 = $signed({2'b00, e_eff}) + SH_OFS;

	// float to fixed: shift left or round half away from zero
	always_comb begin
		logic [9:0]  r;
		logic [48:0] t;
		r    = 10'(-fsh_s2);
		t    = {fmag_s2, 25'd0} >> r[4:0];
		fsat = finf_s2 || (fsh_s2 > 10'sd31);
		if (fsh_s2 >= 10'sd0)
			fq = {31'd0, fmag_s2} << fsh_s2[4:0];
		else if (r > 10'd25)
			fq = '0;
		else
			fq = 55'(t[48:25]) + 55'(t[24]);
	end

	// leading one of the fixed magnitude
	always_comb begin
		xp = '0;
		for (int i = 0; i < 32; i++) begin
			if (xmag_s2[i])
				xp = 5'(i);
		end
	end

	always_comb begin
		logic [31:0] norm;
		logic        rinc, carry;
		logic [24:0] mant;
		logic [7:0]  ex;
		logic [31:0] qlo;
		norm  = xmag_s3 << (5'd31 - xp_s3);
		rinc  = norm[7] && ((|norm[6:0]) || norm[8]);
		mant  = {1'b0, norm[31:8]} + 25'(rinc);
		carry = mant[24];
		ex    = 8'(xp_s3) + EXP_OFS + 8'(carry);
		qlo   = fq_s3[31:0];
		res_nx = '0;
		case (cmd_s3)
			fpa_pkg::CMD_FROM_FLOAT: begin
				if (fnan_s3) begin
					res_nx.status = fpa_pkg::ST_INVAL;
				end else if (fsat_s3 || (fq_s3 > (fneg_s3 ? 55'h80000000 : 55'h7FFFFFFF))) begin
					res_nx.status     = fpa_pkg::ST_OVF;
					res_nx.result_raw = fneg_s3 ? 32'sh80000000 : 32'sh7FFFFFFF;
				end else begin
					res_nx.result_raw = fneg_s3 ? -qlo : qlo;
				end
			end
			fpa_pkg::CMD_TO_FLOAT: begin
				if (!xzero_s3)
					res_nx.float_result_bits = {xneg_s3, ex,
						carry ? 23'd0 : mant[22:0]};
			end
			default: res_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd;
			fneg_s2 <= scalar[31];
			fnan_s2 <= (scalar[30:23] == 8'hFF) && (scalar[22:0] != '0);
			finf_s2 <= (scalar[30:23] == 8'hFF) && (scalar[22:0] == '0);
			fmag_s2 <= {(scalar[30:23] != 8'd0), scalar[22:0]};
			fsh_s2  <= sh_s1;
			xneg_s2 <= a[31];
			xmag_s2 <= a[31] ? 32'(-a) : 32'(a);

			cmd_s3   <= cmd_s2;
			fneg_s3  <= fneg_s2;
			fnan_s3  <= fnan_s2;
			fsat_s3  <= fsat;
			fq_s3    <= fq;
			xneg_s3  <= xneg_s2;
			xzero_s3 <= (xmag_s2 == '0);
			xmag_s3  <= xmag_s2;
			xp_s3    <= xp;

			res_s4 <= res_nx;
		end
	end

	assign res = res_s4;

endmodule

`default_nettype wire

@@ hw/rtl/fixed_point_alu_q24_8.sv @@
// ---------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 ALU: arithmetic, compares, min/max and conversions.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   cmd, a_raw, b_raw, scalar_in
//   out_ch   out  valid/ready   result_raw, compare_true, int_result,
//                               float_result_bits, status
//
// One item per cycle unless the pipeline holds; every item passes 22
// registers (input register, 20-stage divider with two quotient bits per
// stage, output register) on its way to the output channel. Other
// commands run in 3 stages and are delayed to match, so results leave in
// order. Reset clears only the valid bits.
// The whole pipeline holds when the output item is not taken.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8 (
	input wire logic  clk,
	input wire logic  arst_n,
	fpa_in_if.sink    in_ch,
	fpa_out_if.source out_ch
);

	localparam int ND  = fpa_pkg::PIPE_DEPTH;
	localparam int NS  = fpa_pkg::DIV_STAGES;
	localparam int NSD = fpa_pkg::SIDE_DLY;
	localparam int DW  = fpa_pkg::DVD_W;
	localparam int FB  = fpa_pkg::FRAC_BITS;

	logic               en;
	logic               vld_s [ND];
	logic [4:0]         cmd_s1;
	logic signed [31:0] a_s1, b_s1;
	logic [31:0]        sc_s1;

	logic [31:0]         a_mag, b_mag;
	logic [DW-1:0]       dividend, quotient;
	fpa_pkg::div_tag_t   tag_s [NS];
	fpa_pkg::res_t       arith_res, cvt_res, side;
	fpa_pkg::res_t       side_s [NSD];
	fpa_pkg::res_t       fin, out_res_q;

	assign en          = !vld_s[ND-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ND; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_ch.valid;
			for (int i = 1; i < ND; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.cmd;
			a_s1   <= in_ch.a_raw;
			b_s1   <= in_ch.b_raw;
			sc_s1  <= in_ch.scalar_in;
		end
	end

	assign a_mag    = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
	assign b_mag    = b_s1[31] ? 32'(-b_s1) : 32'(b_s1);
	assign dividend = DW'({a_mag, {FB{1'b0}}});

	fpa_div u_div (
		.clk      (clk),
		.en       (en),
		.dividend (dividend),
		.divisor  (b_mag),
		.quotient (quotient)
	);

	fpa_arith u_arith (
		.clk    (clk),
		.en     (en),
		.cmd    (cmd_s1),
		.a      (a_s1),
		.b      (b_s1),
		.scalar (sc_s1),
		.res    (arith_res)
	);

	fpa_cvt u_cvt (
		.clk    (clk),
		.en     (en),
		.cmd    (cmd_s1),
		.a      (a_s1),
		.scalar (sc_s1),
		.res    (cvt_res)
	);

	// each unit drives zeros for commands it does not own
	assign side = arith_res | cvt_res;

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0].is_div <= (cmd_s1 == fpa_pkg::CMD_DIV);
			tag_s[0].neg    <= a_s1[31] ^ b_s1[31];
			tag_s[0].zero   <= (b_s1 == '0);
			for (int i = 1; i < NS; i++)
				tag_s[i] <= tag_s[i-1];
			side_s[0] <= side;
			for (int i = 1; i < NSD; i++)
				side_s[i] <= side_s[i-1];
			out_res_q <= fin;
		end
	end

	always_comb begin
		logic [31:0] qlo;
		logic        hi_zero;
		qlo     = quotient[31:0];
		hi_zero = (quotient[DW-1:31] == '0);
		fin     = '0;
		if (!tag_s[NS-1].is_div) begin
			fin = side_s[NSD-1];
		end else if (tag_s[NS-1].zero) begin
			fin.status = fpa_pkg::ST_DIV0;
		end else begin
			fin.result_raw = tag_s[NS-1].neg ? -qlo : qlo;
			if (!(hi_zero || (tag_s[NS-1].neg && quotient == DW'(33'h080000000))))
				fin.status = fpa_pkg::ST_OVF;
		end
	end

	assign out_ch.valid             = vld_s[ND-1];
	assign out_ch.result_raw        = out_res_q.result_raw;
	assign out_ch.compare_true      = out_res_q.compare_true;
	assign out_ch.int_result        = out_res_q.int_result;
	assign out_ch.float_result_bits = out_res_q.float_result_bits;
	assign out_ch.status            = out_res_q.status;

`ifndef SYNTH
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_s[0])
		else $error("accepted item did not enter stage 1");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == fpa_pkg::ST_DIV0 |->
		out_ch.result_raw == '0 && !out_ch.compare_true)
		else $error("divide by zero item carries a result");

	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == fpa_pkg::ST_INVAL |->
		out_ch.result_raw == '0 && out_ch.float_result_bits == '0)
		else $error("invalid float item carries a result");

	a_cmp_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.compare_true |->
		out_ch.result_raw == '0 && out_ch.int_result == '0 &&
		out_ch.float_result_bits == '0 && out_ch.status == fpa_pkg::ST_OK)
		else $error("compare item has other fields set");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the Q24.8 ALU: directed and random operations are driven on
// the input channel, and each result is compared field by field with an
// in-order prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import fpa_pkg::*;

	typedef struct packed {
		logic [4:0]         cmd;
		logic signed [31:0] a_raw;
		logic signed [31:0] b_raw;
		logic [31:0]        scalar_in;
	} alu_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpa_in_if  in_ch();
	fpa_out_if out_ch();

	fixed_point_alu_q24_8 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	alu_op_t pending_ops[$];
	res_t    expected_res[$];
	int      n_errors = 0;
	bit      stim_done = 1'b0;
	int      hold_after = -1;   // op index after which the sender waits for drain
	int      stall_start = -1;  // op index at which the receiver stalls long
	int      ops_sent = 0;
	bit      in_taken = 1'b0;   // input item accepted at the last rising edge
	bit      out_taken = 1'b0;  // output item accepted at the last rising edge

	function automatic logic [31:0] float_to_q(input logic [31:0] bits,
		output logic [1:0] st);
		logic        neg;
		int          e, sh, r;
		logic [63:0] mag, q, lim;
		neg = bits[31];
		e   = bits[30:23];
		mag = {41'd0, bits[22:0]};
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		st  = ST_OK;
		if (e == 255) begin
			if (mag != 0) begin
				st = ST_INVAL;
				return 32'd0;
			end
			st = ST_OVF;
			return lim[31:0];
		end
		if (e == 0) begin
			sh = -149 + FRAC_BITS;
		end else begin
			mag[23] = 1'b1;
			sh = e - 150 + FRAC_BITS;
		end
		if (mag == 0)
			return 32'd0;
		if (sh >= 0) begin
			if (sh > 31) begin
				st = ST_OVF;
				return lim[31:0];
			end
			q = mag << sh;
		end else begin
			r = -sh;
			if (r > 25)
				q = 0;
			else
				q = (mag + (64'd1 << (r - 1))) >> r;
		end
		if (q > lim) begin
			st = ST_OVF;
			return lim[31:0];
		end
		return neg ? (32'd0 - q[31:0]) : q[31:0];
	endfunction

	function automatic logic [31:0] q_to_float(input logic signed [31:0] a);
		logic        neg;
		logic [63:0] mag, mant, rem, half;
		int          p, s;
		neg = a[31];
		mag = neg ? -64'(signed'(a)) : 64'(a);
		p = 0;
		if (mag == 0)
			return 32'd0;
		while (p < 40 && (mag >> (p + 1)) != 0)
			p++;
		if (p <= 23) begin
			mant = mag << (23 - p);
		end else begin
			s    = p - 23;
			rem  = mag & ((64'd1 << s) - 1);
			half = 64'd1 << (s - 1);
			mant = mag >> s;
			if (rem > half || (rem == half && mant[0]))
				mant++;
			if (mant == (64'd1 << 24)) begin
				mant >>= 1;
				p++;
			end
		end
		return {neg, 8'(p - FRAC_BITS + 127), mant[22:0]};
	endfunction

	function automatic res_t alu_predict(input alu_op_t op);
		res_t               r;
		logic signed [63:0] a, b, v, fl;
		bit                 wrap;
		r    = '0;
		a    = op.a_raw;
		b    = op.b_raw;
		wrap = 1'b0;
		v    = 0;
		case (op.cmd)
			CMD_ADD: begin v = a + b; wrap = 1; end
			CMD_SUB: begin v = a - b; wrap = 1; end
			CMD_MUL: begin v = (a * b) >>> FRAC_BITS; wrap = 1; end
			CMD_DIV: begin
				if (b == 0) begin
					r.status = ST_DIV0;
				end else begin
					v = (a * (64'sd1 <<< FRAC_BITS)) / b;
					wrap = 1;
				end
			end
			CMD_LT: r.compare_true = a < b;
			CMD_LE: r.compare_true = a <= b;
			CMD_GT: r.compare_true = a > b;
			CMD_GE: r.compare_true = a >= b;
			CMD_EQ: r.compare_true = a == b;
			CMD_MIN: r.result_raw = (a < b) ? op.a_raw : op.b_raw;
			CMD_MAX: r.result_raw = (a > b) ? op.a_raw : op.b_raw;
			CMD_FROM_INT: begin
				v = 64'(signed'(op.scalar_in)) * (64'sd1 <<< FRAC_BITS);
				wrap = 1;
			end
			CMD_TO_INT: begin
				fl = a >>> FRAC_BITS;
				if (fl < -64'sd8388608 || fl > 64'sd8388607)
					r.status = ST_OVF;
				r.int_result = fl[23:0];
			end
			CMD_FROM_FLOAT: r.result_raw = float_to_q(op.scalar_in, r.status);
			CMD_TO_FLOAT: r.float_result_bits = q_to_float(op.a_raw);
			CMD_INC: begin v = a + 1; wrap = 1; end
			CMD_DEC: begin v = a - 1; wrap = 1; end
			default: ;
		endcase
		if (wrap) begin
			if (v < -64'sd2147483648 || v > 64'sd2147483647)
				r.status = ST_OVF;
			r.result_raw = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? $urandom_range(0, 2048)
				: -$urandom_range(0, 2048);
			3: return 32'(signed'($urandom_range(0, 65535) - 32768)) << 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_float();
		logic [7:0] e;
		case ($urandom_range(0, 4))
			0: e = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			1: e = 8'($urandom_range(150, 160));
			default: e = 8'($urandom_range(100, 155));
		endcase
		return {1'($urandom), e, 23'($urandom)};
	endfunction

	task automatic add_op(input logic [4:0] c, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] s);
		pending_ops.push_back('{c, a, b, s});
	endtask

	initial begin
		alu_op_t op;
		add_op(CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'd0);
		add_op(CMD_SUB, 32'h8000_0000, 32'd1, 32'd0);
		add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'd0);
		add_op(CMD_MUL, -32'd1, 32'd1, 32'd0);
		add_op(CMD_DIV, 32'd256, 32'd0, 32'd0);
		add_op(CMD_DIV, 32'h8000_0000, -32'd256, 32'd0);
		add_op(CMD_DIV, -32'd300, 32'd7, 32'd0);
		add_op(CMD_LT, 32'd5, 32'd5, 32'd0);
		add_op(CMD_LE, 32'd5, 32'd5, 32'd0);
		add_op(CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		add_op(CMD_GE, -32'd1, 32'd0, 32'd0);
		add_op(CMD_EQ, 32'd7, 32'd7, 32'd0);
		add_op(CMD_MIN, 32'd9, 32'd9, 32'd0);
		add_op(CMD_MAX, -32'd3, 32'd4, 32'd0);
		add_op(CMD_FROM_INT, 32'd0, 32'd0, 32'h0080_0000);
		add_op(CMD_TO_INT, 32'h8000_0000, 32'd0, 32'd0);
		add_op(CMD_TO_INT, -32'd1, 32'd0, 32'd0);
		add_op(CMD_FROM_FLOAT, 32'd0, 32'd0, 32'h7FC0_0000);  // NaN
		add_op(CMD_FROM_FLOAT, 32'd0, 32'd0, 32'hFF80_0000);  // -inf
		add_op(CMD_FROM_FLOAT, 32'd0, 32'd0, 32'h8000_0000);  // -0
		add_op(CMD_FROM_FLOAT, 32'd0, 32'd0, 32'h3B80_0000);  // one unit (2^-8), exactly representable
		add_op(CMD_FROM_FLOAT, 32'd0, 32'd0, 32'h0000_0001);  // denormal
		add_op(CMD_TO_FLOAT, 32'h8000_0000, 32'd0, 32'd0);
		add_op(CMD_TO_FLOAT, 32'h7FFF_FFFF, 32'd0, 32'd0);
		add_op(CMD_INC, 32'h7FFF_FFFF, 32'd0, 32'd0);
		add_op(CMD_DEC, 32'h8000_0000, 32'd0, 32'd0);
		add_op(5'd31, 32'h1234_5678, 32'd1, 32'd1);
		hold_after  = pending_ops.size();
		stall_start = hold_after + 200;
		repeat (750) begin
			op.cmd       = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			op.a_raw     = rand_word();
			op.b_raw     = ($urandom_range(0, 9) == 0) ? 32'd0
				: ($urandom_range(0, 5) == 0 ? op.a_raw : rand_word());
			op.scalar_in = (op.cmd == CMD_FROM_FLOAT) ? rand_float() : rand_word();
			pending_ops.push_back(op);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	int send_gap = 0;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.a_raw = '0;
		in_ch.b_raw = '0;
		in_ch.scalar_in = '0;
	end

	// input handshake is seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_res.push_back(alu_predict({in_ch.cmd, in_ch.a_raw,
				in_ch.b_raw, in_ch.scalar_in}));
			ops_sent++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		bit took;
		took = in_taken;
		in_taken = 1'b0;
		if (arst_n) begin
			if (took) begin
				send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
				if (ops_sent % 200 > 150)
					send_gap = 0;
			end
			if (!in_ch.valid || took) begin
				if (ops_sent == hold_after && expected_res.size() != 0) begin
					in_ch.valid <= 1'b0;
				end else if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					alu_op_t op;
					op = pending_ops.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.cmd       <= op.cmd;
					in_ch.a_raw     <= op.a_raw;
					in_ch.b_raw     <= op.b_raw;
					in_ch.scalar_in <= op.scalar_in;
				end else begin
					in_ch.valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	int  sink_gap = 0;
	int  long_hold = 0;
	bit  long_done = 1'b0;
	initial out_ch.ready = 1'b0;

	always @(negedge clk) begin
		bit took;
		took = out_taken;
		out_taken = 1'b0;
		if (arst_n) begin
			if (took)
				sink_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
			if (!long_done && ops_sent >= stall_start) begin
				long_done = 1'b1;
				long_hold = 200;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			out_taken = 1'b1;
			got = {out_ch.result_raw, out_ch.compare_true, out_ch.int_result,
				out_ch.float_result_bits, out_ch.status};
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_errors++;
			end else begin
				want = expected_res.pop_front();
				if (got.result_raw !== want.result_raw) begin
					$display("%0t: result_raw exp %h got %h", $time,
						want.result_raw, got.result_raw);
					n_errors++;
				end
				if (got.compare_true !== want.compare_true) begin
					$display("%0t: compare_true exp %b got %b", $time,
						want.compare_true, got.compare_true);
					n_errors++;
				end
				if (got.int_result !== want.int_result) begin
					$display("%0t: int_result exp %h got %h", $time,
						want.int_result, got.int_result);
					n_errors++;
				end
				if (got.float_result_bits !== want.float_result_bits) begin
					$display("%0t: float_result_bits exp %h got %h", $time,
						want.float_result_bits, got.float_result_bits);
					n_errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time,
						want.status, got.status);
					n_errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && expected_res.size() == 0);
		repeat (60) @(posedge clk);
		if (n_errors == 0 && expected_res.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_if.sv
hw/rtl/fpa_div.sv
hw/rtl/fpa_arith.sv
hw/rtl/fpa_cvt.sv
hw/rtl/fixed_point_alu_q24_8.sv
sim/tb_top.sv
